/* rtl/rspb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspb_pkg
// Shared types and constants for the run-length sprite palette blitter.
// ----------------------------------------------------------------------------
package rspb_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int ADDR_BITS_DEF     = 24;

    localparam int OP_W          = 2;
    localparam int BYTE_W        = 8;
    localparam int COLOR_W       = 16;
    localparam int PIX_ADDR_W    = 24;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 24;

    localparam int BASE_W        = 24;
    localparam int POS_W         = 12;
    localparam int DIM_W         = 10;
    localparam int PITCH_W       = 12;
    localparam int COLUMN_W      = 11;
    localparam int ROW_W         = 10;
    localparam int RUN_W         = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PALETTE = 2'd0,
        OP_START   = 2'd1,
        OP_CODE    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SKIP    = 2'd1,
        PH_LITERAL = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEST_BASE     = 3'd0,
        CFG_ORIGIN_X      = 3'd1,
        CFG_ORIGIN_Y      = 3'd2,
        CFG_SPRITE_WIDTH  = 3'd3,
        CFG_SPRITE_HEIGHT = 3'd4,
        CFG_PITCH_WORDS   = 3'd5,
        CFG_SKIP_MARKER   = 3'd6
    } cfg_reg_t;

endpackage

/* rtl/rle_sprite_palette_blitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_palette_blitter
// Turns a run-length coded sprite byte stream into 16-bit pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall) carries one beat per operation:
//   a palette write, a sprite start, or one code byte of the stream.
//   result channel (result_valid / result_stall) carries a pixel write, or a
//   done beat when the last row of the sprite completes or an empty sprite starts.
//   cfg channel (cfg_valid / cfg_ready, always ready) sets placement, size,
//   pitch and skip marker; write it only while the block is idle.
// Throughput: one item per cycle while item_stall is low, set by the single
//   parser step and the one palette read port.
// Path: an accepted item's result is registered in the middle stage, alongside
//   the palette read, and then in the result register.
// Stall: while the result register is full and stalled, one more result is
//   held in the stage behind it; after that item_stall rises until the
//   receiver takes a beat.
// Reset: parser idle and finished; configuration, parser and valid registers
//   zero; data registers and palette contents stay undefined until written.
// ----------------------------------------------------------------------------
module rle_sprite_palette_blitter
#(
    parameter int PALETTE_DEPTH = rspb_pkg::PALETTE_DEPTH_DEF,
    parameter int ADDR_BITS     = rspb_pkg::ADDR_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rspb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rspb_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [rspb_pkg::OP_W-1:0]         operation,
    input  logic [rspb_pkg::BYTE_W-1:0]       palette_index,
    input  logic [rspb_pkg::COLOR_W-1:0]      palette_color,
    input  logic [rspb_pkg::BYTE_W-1:0]       code_byte,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              pixel_write,
    output logic [rspb_pkg::PIX_ADDR_W-1:0]   pixel_address,
    output logic [rspb_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              sprite_done
);

    import rspb_pkg::*;

    localparam int IDX_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int WIDE_W = (ADDR_BITS > PIX_ADDR_W) ? ADDR_BITS : PIX_ADDR_W;

    // configuration
    logic [BASE_W-1:0]  dest_base_reg;
    logic [POS_W-1:0]   origin_x_reg;
    logic [POS_W-1:0]   origin_y_reg;
    logic [DIM_W-1:0]   sprite_width_reg;
    logic [DIM_W-1:0]   sprite_height_reg;
    logic [PITCH_W-1:0] pitch_words_reg;
    logic [BYTE_W-1:0]  skip_marker_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [RUN_W-1:0]    run_left_reg, run_left_next;
    logic [ADDR_BITS-1:0] row_addr_reg, row_addr_next;
    logic                finished_reg, finished_next;

    // middle stage and result register
    logic                 s1_valid_reg;
    logic                 s1_write_reg;
    logic                 s1_hit_reg;
    logic                 s1_done_reg;
    logic [PIX_ADDR_W-1:0] s1_addr_reg;
    logic [COLOR_W-1:0]   rdata_reg;

    logic                 result_valid_reg;
    logic                 pixel_write_reg;
    logic [PIX_ADDR_W-1:0] pixel_address_reg;
    logic [COLOR_W-1:0]   pixel_color_reg;
    logic                 sprite_done_reg;

    logic [COLOR_W-1:0]   palette_mem [PALETTE_DEPTH];

    op_t                  op;
    logic                 accept;
    logic                 s1_adv;
    logic                 is_code;
    logic                 pal_we;
    logic                 rd_hit;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     rd_idx;

    logic [2*POS_W-1:0]   origin_prod;
    logic [ADDR_BITS-1:0] start_addr;
    logic [COLUMN_W-1:0]  col_run;
    logic                 row_end;
    logic [ROW_W-1:0]     row_inc;
    logic                 sprite_end;
    logic                 lit_last;
    logic                 is_skip;
    logic [ADDR_BITS-1:0] pix_sum;
    logic [WIDE_W-1:0]    pix_wide;

    logic                 res_valid;
    logic                 res_write;
    logic                 res_done;

    assign op        = op_t'(operation);
    assign cfg_ready = 1'b1;

    assign s1_adv     = !result_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !s1_adv;
    assign accept     = item_valid && !item_stall;

    assign is_code = (op == OP_CODE) && !finished_reg;
    assign is_skip = (code_byte == skip_marker_reg);
    assign pal_we  = accept && (op == OP_PALETTE)
                     && ({1'b0, palette_index} < (BYTE_W + 1)'(PALETTE_DEPTH));
    assign rd_hit  = {1'b0, code_byte} < (BYTE_W + 1)'(PALETTE_DEPTH);
    assign wr_idx  = palette_index[IDX_W-1:0];
    assign rd_idx  = code_byte[IDX_W-1:0];

    // start position
    assign origin_prod = origin_y_reg * pitch_words_reg;
    assign start_addr  = ADDR_BITS'(dest_base_reg) + ADDR_BITS'(origin_prod)
                         + ADDR_BITS'(origin_x_reg);

    // end of run tests
    always_comb
    begin
        unique case (phase_reg)
            PH_SKIP:    col_run = column_reg + COLUMN_W'(code_byte);
            PH_LITERAL: col_run = column_reg + COLUMN_W'(1);
            default:    col_run = column_reg;
        endcase
    end

    assign row_end    = col_run >= COLUMN_W'(sprite_width_reg);
    assign row_inc    = row_reg + ROW_W'(1);
    assign sprite_end = row_end && (row_inc >= sprite_height_reg);
    assign lit_last   = (run_left_reg == RUN_W'(1));

    assign pix_sum  = row_addr_reg + ADDR_BITS'(column_reg);
    assign pix_wide = WIDE_W'(pix_sum);

    // parser next state
    always_comb
    begin
        phase_next    = phase_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        run_left_next = run_left_reg;
        row_addr_next = row_addr_reg;
        finished_next = finished_reg;
        if (accept && op == OP_START)
        begin
            phase_next    = PH_HEADER;
            column_next   = '0;
            row_next      = '0;
            run_left_next = '0;
            row_addr_next = start_addr;
            finished_next = (sprite_height_reg == '0) || (sprite_width_reg == '0);
        end
        else if (accept && is_code)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (is_skip)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (code_byte != '0)
                    begin
                        run_left_next = code_byte;
                        phase_next    = PH_LITERAL;
                    end
                end
                PH_SKIP:
                begin
                    column_next = col_run;
                end
                PH_LITERAL:
                begin
                    column_next   = col_run;
                    run_left_next = run_left_reg - RUN_W'(1);
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
            // run finished: skip count, last literal, or empty literal header
            if ((phase_reg == PH_SKIP) || (phase_reg == PH_LITERAL && lit_last)
                || (phase_reg == PH_HEADER && !is_skip && code_byte == '0))
            begin
                phase_next = PH_HEADER;
                if (row_end)
                begin
                    column_next   = '0;
                    row_next      = row_inc;
                    row_addr_next = row_addr_reg + ADDR_BITS'(pitch_words_reg);
                    finished_next = sprite_end;
                end
            end
        end
    end

    // result of this item
    always_comb
    begin
        res_valid = 1'b0;
        res_write = 1'b0;
        res_done  = 1'b0;
        if (op == OP_START)
        begin
            res_valid = (sprite_height_reg == '0) || (sprite_width_reg == '0);
            res_done  = res_valid;
        end
        else if (is_code)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    res_valid = sprite_end;
                    res_done  = sprite_end;
                end
                PH_LITERAL:
                begin
                    res_valid = 1'b1;
                    res_write = 1'b1;
                    res_done  = lit_last && sprite_end;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_base_reg     <= '0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            sprite_width_reg  <= '0;
            sprite_height_reg <= '0;
            pitch_words_reg   <= '0;
            skip_marker_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DEST_BASE:     dest_base_reg     <= cfg_data[BASE_W-1:0];
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data[POS_W-1:0];
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[DIM_W-1:0];
                CFG_PITCH_WORDS:   pitch_words_reg   <= cfg_data[PITCH_W-1:0];
                CFG_SKIP_MARKER:   skip_marker_reg   <= cfg_data[BYTE_W-1:0];
                default:           dest_base_reg     <= dest_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            column_reg   <= '0;
            row_reg      <= '0;
            run_left_reg <= '0;
            row_addr_reg <= '0;
            finished_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            run_left_reg <= run_left_next;
            row_addr_reg <= row_addr_next;
            finished_reg <= finished_next;
        end
    end

    // palette store
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            palette_mem[wr_idx] <= palette_color;
        end
        if (accept && op == OP_CODE)
        begin
            rdata_reg <= palette_mem[rd_idx];
        end
    end

    // middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            s1_write_reg <= res_write;
            s1_hit_reg   <= rd_hit;
            s1_done_reg  <= res_done;
            s1_addr_reg  <= res_write ? pix_wide[PIX_ADDR_W-1:0] : '0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            pixel_write_reg   <= s1_write_reg;
            pixel_address_reg <= s1_addr_reg;
            pixel_color_reg   <= (s1_write_reg && s1_hit_reg) ? rdata_reg : '0;
            sprite_done_reg   <= s1_done_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pixel_write   = pixel_write_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;
    assign sprite_done   = sprite_done_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg && result_stall))
        else $error("item stall without a full pipeline");

    a_finished_header: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (phase_reg == PH_HEADER))
        else $error("parser left header phase while finished");

    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && !(accept && op == OP_START)) |=> finished_reg)
        else $error("sprite restarted without a start beat");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !pixel_write) |-> (pixel_address == '0 && pixel_color == '0))
        else $error("non-write result carries address or colour");

    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && res_done) |=> finished_reg)
        else $error("done beat without finished parser");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the run-length sprite palette blitter.
// Palette writes, sprite starts and code byte streams are driven in bursts,
// and the result side is stalled on its own pattern. A software model of the
// parser predicts every pixel and done beat. A scoreboard checks each beat in
// order against those predictions. Configuration changes only while idle.
// ----------------------------------------------------------------------------
module tb;

    import rspb_pkg::*;

    typedef struct packed {
        logic        wr;
        logic [23:0] addr;
        logic [15:0] color;
        logic        done;
    } pixel_beat_t;

    class blit_scoreboard;
        logic [15:0] palette [256];
        phase_t      phase;
        logic [10:0] column;
        logic [9:0]  row;
        logic [7:0]  run_left;
        logic [23:0] row_addr;
        bit          finished;

        logic [23:0] dest_base;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [9:0]  width;
        logic [9:0]  height;
        logic [11:0] pitch;
        logic [7:0]  marker;

        pixel_beat_t pixel_q [$];
        int          errors;
        int          beats;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            phase     = PH_HEADER;
            column    = '0;
            row       = '0;
            run_left  = '0;
            row_addr  = '0;
            finished  = 1'b1;
            dest_base = '0;
            origin_x  = '0;
            origin_y  = '0;
            width     = '0;
            height    = '0;
            pitch     = '0;
            marker    = '0;
            errors    = 0;
            beats     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [23:0] data);
            case (idx)
                CFG_DEST_BASE:     dest_base = data;
                CFG_ORIGIN_X:      origin_x  = data[11:0];
                CFG_ORIGIN_Y:      origin_y  = data[11:0];
                CFG_SPRITE_WIDTH:  width     = data[9:0];
                CFG_SPRITE_HEIGHT: height    = data[9:0];
                CFG_PITCH_WORDS:   pitch     = data[11:0];
                CFG_SKIP_MARKER:   marker    = data[7:0];
                default: ;
            endcase
        endfunction

        // row bookkeeping after a run; true when the last row has completed
        function bit close_run();
            phase = PH_HEADER;
            if (column < width)
                return 1'b0;
            column   = '0;
            row      = row + 10'd1;
            row_addr = row_addr + pitch;
            if (row >= height)
            begin
                finished = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] pidx, logic [15:0] pcol,
                                logic [7:0] b);
            pixel_beat_t r;
            logic [47:0] start_addr;
            r = '0;
            case (op)
                OP_PALETTE:
                    palette[pidx] = pcol;
                OP_START:
                begin
                    phase      = PH_HEADER;
                    column     = '0;
                    row        = '0;
                    run_left   = '0;
                    start_addr = dest_base + origin_y * pitch + origin_x;
                    row_addr   = start_addr[23:0];
                    finished   = (height == 0 || width == 0);
                    if (finished)
                    begin
                        r.done = 1'b1;
                        pixel_q.push_back(r);
                    end
                end
                OP_CODE:
                begin
                    if (!finished)
                    begin
                        case (phase)
                            PH_HEADER:
                            begin
                                if (b == marker)
                                    phase = PH_SKIP;
                                else if (b == 8'd0)
                                    void'(close_run());
                                else
                                begin
                                    run_left = b;
                                    phase    = PH_LITERAL;
                                end
                            end
                            PH_SKIP:
                            begin
                                column = column + b;
                                if (close_run())
                                begin
                                    r.done = 1'b1;
                                    pixel_q.push_back(r);
                                end
                            end
                            default:
                            begin
                                r.wr     = 1'b1;
                                r.addr   = row_addr + column;
                                r.color  = palette[b];
                                column   = column + 11'd1;
                                run_left = run_left - 8'd1;
                                if (run_left == 0)
                                    r.done = close_run();
                                pixel_q.push_back(r);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic wr, logic [23:0] addr, logic [15:0] color, logic done);
            pixel_beat_t want;
            beats++;
            if (pixel_q.size() == 0)
            begin
                report($sformatf("beat %0d: no result expected (wr %b addr %h colour %h done %b)",
                                 beats, wr, addr, color, done));
                return;
            end
            want = pixel_q.pop_front();
            if (wr !== want.wr)
                report($sformatf("beat %0d: pixel_write got %b want %b", beats, wr, want.wr));
            if (addr !== want.addr)
                report($sformatf("beat %0d: pixel_address got %h want %h", beats, addr,
                                 want.addr));
            if (color !== want.color)
                report($sformatf("beat %0d: pixel_color got %h want %h", beats, color,
                                 want.color));
            if (done !== want.done)
                report($sformatf("beat %0d: sprite_done got %b want %b", beats, done, want.done));
        endtask

        function int pending();
            return pixel_q.size();
        endfunction

        function void flush();
            pixel_q.delete();
        endfunction
    endclass

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1150;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  operation;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic [7:0]  code_byte;
    logic        result_valid;
    logic        result_stall;
    logic        pixel_write;
    logic [23:0] pixel_address;
    logic [15:0] pixel_color;
    logic        sprite_done;

    blit_scoreboard sb;

    bit          pal_written [256];
    int          items_sent;
    int          burst_left;
    logic [9:0]  cur_w;
    logic [9:0]  cur_h;
    logic [7:0]  cur_m;

    rle_sprite_palette_blitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .code_byte     (code_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .pixel_write   (pixel_write),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .sprite_done   (sprite_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        int len;
        int k;
        result_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            for (k = 0; k < len; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: result_stall = 1'b0;
                    1: result_stall = ($urandom_range(0, 3) == 0);
                    2: result_stall = 1'($urandom_range(0, 1));
                    default: result_stall = ((k % 9) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_beat(pixel_write, pixel_address, pixel_color, sprite_done);
    end

    task send_item(logic [1:0] op, logic [7:0] pidx, logic [15:0] pcol, logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
        end
        item_valid    = 1'b1;
        operation     = op;
        palette_index = pidx;
        palette_color = pcol;
        code_byte     = b;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(op, pidx, pcol, b);
        items_sent++;
        burst_left--;
    endtask

    task send_palette(logic [7:0] idx, logic [15:0] color);
        send_item(OP_PALETTE, idx, color, 8'($urandom));
        pal_written[idx] = 1'b1;
    endtask

    // a code byte may land as a literal index, so its entry is filled first
    task send_code(logic [7:0] b);
        if (!pal_written[b])
            send_palette(b, 16'($urandom));
        send_item(OP_CODE, 8'($urandom), 16'($urandom), b);
    endtask

    task set_reg(cfg_reg_t idx, logic [23:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        case (idx)
            CFG_SPRITE_WIDTH:  cur_w = data[9:0];
            CFG_SPRITE_HEIGHT: cur_h = data[9:0];
            CFG_SKIP_MARKER:   cur_m = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task wait_idle();
        int guard;
        @(negedge clk);
        item_valid = 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
            sb.flush();
        end
        repeat (8) @(posedge clk);
    endtask

    // well-formed stream for up to max_rows rows of the current sprite
    task send_sprite(int max_rows);
        int rows;
        int r;
        int col;
        int rem;
        int n;
        int pick;
        int k;
        send_item(OP_START, 8'($urandom), 16'($urandom), 8'($urandom));
        if (cur_w == 0 || cur_h == 0)
            return;
        rows = (max_rows < cur_h) ? max_rows : cur_h;
        for (r = 0; r < rows; r++)
        begin
            col = 0;
            while (col < cur_w)
            begin
                rem  = cur_w - col;
                pick = $urandom_range(0, 9);
                if (rem > 40 && pick < 7)
                    pick = 0;
                if (pick < 3)
                begin
                    send_code(cur_m);
                    if ($urandom_range(0, 5) == 0)
                        n = $urandom_range(0, 255);
                    else
                        n = $urandom_range(0, (rem > 255) ? 255 : rem);
                    send_code(8'(n));
                    col += n;
                end
                else if (pick == 3 && cur_m != 0)
                    send_code(8'd0);
                else
                begin
                    if ($urandom_range(0, 4) == 0)
                        n = rem + $urandom_range(0, 3);
                    else
                        n = $urandom_range(1, (rem > 8) ? 8 : rem);
                    if (n > 255)
                        n = 255;
                    if (n == cur_m)
                        n = (n > 1) ? n - 1 : n + 1;
                    send_code(8'(n));
                    for (k = 0; k < n; k++)
                        send_code(8'($urandom));
                    col += n;
                end
            end
        end
    endtask

    task send_noise(int count);
        int k;
        logic [1:0] op;
        for (k = 0; k < count; k++)
        begin
            op = 2'($urandom_range(0, 3));
            if (op == OP_CODE)
                send_code(8'($urandom));
            else if (op == OP_PALETTE)
                send_palette(8'($urandom), 16'($urandom));
            else
                send_item(op, 8'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task pick_config();
        int s;
        if ($urandom_range(0, 2) != 0)
        begin
            s = $urandom_range(0, 3);
            set_reg(CFG_DEST_BASE, (s == 0) ? 24'd0 : (s == 1) ? 24'hFFFFFF : 24'($urandom));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            s = $urandom_range(0, 3);
            set_reg(CFG_ORIGIN_X, (s == 0) ? 24'd0 : (s == 1) ? 24'd4095 :
                                  24'($urandom_range(0, 4095)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            s = $urandom_range(0, 3);
            set_reg(CFG_ORIGIN_Y, (s == 0) ? 24'd0 : (s == 1) ? 24'd4095 :
                                  24'($urandom_range(0, 4095)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            s = $urandom_range(0, 3);
            set_reg(CFG_PITCH_WORDS, (s == 0) ? 24'd0 : (s == 1) ? 24'd4095 :
                                     24'($urandom_range(0, 4095)));
        end
        s = $urandom_range(0, 11);
        set_reg(CFG_SPRITE_WIDTH, (s == 0) ? 24'd0 : (s == 1) ? 24'd1023 : (s == 2) ? 24'd1 :
                                  24'($urandom_range(1, 8)));
        s = $urandom_range(0, 11);
        set_reg(CFG_SPRITE_HEIGHT, (s == 0) ? 24'd0 : (s == 1) ? 24'd1023 :
                                   24'($urandom_range(1, 4)));
        if ($urandom_range(0, 1) != 0)
        begin
            s = $urandom_range(0, 3);
            set_reg(CFG_SKIP_MARKER, (s == 0) ? 24'd0 : (s == 1) ? 24'd255 :
                                     24'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        item_valid    = 1'b0;
        operation     = '0;
        palette_index = '0;
        palette_color = '0;
        code_byte     = '0;
        items_sent    = 0;
        burst_left    = 0;
        cur_w         = '0;
        cur_h         = '0;
        cur_m         = '0;
        foreach (pal_written[i])
            pal_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed: address extremes, literal, skip, zero literal, overshoot
        set_reg(CFG_DEST_BASE, 24'hFFFFFF);
        set_reg(CFG_ORIGIN_X, 24'd4095);
        set_reg(CFG_ORIGIN_Y, 24'd4095);
        set_reg(CFG_PITCH_WORDS, 24'd4095);
        set_reg(CFG_SPRITE_WIDTH, 24'd4);
        set_reg(CFG_SPRITE_HEIGHT, 24'd2);
        set_reg(CFG_SKIP_MARKER, 24'd255);
        send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
        send_palette(8'h00, 16'h0000);
        send_palette(8'hFF, 16'hFFFF);
        send_palette(8'h5A, 16'hA5A5);
        send_code(8'h5A);
        send_item(OP_START, 8'h00, 16'h0000, 8'h00);
        send_code(8'd2);
        send_code(8'h00);
        send_code(8'hFF);
        send_code(8'hFF);
        send_code(8'd2);
        send_code(8'd0);
        send_code(8'd5);
        send_code(8'h5A);
        send_code(8'hFF);
        send_code(8'h00);
        send_code(8'h5A);
        send_code(8'hFF);
        send_code(8'h5A);
        wait_idle();

        // empty sprites and a skip that finishes the sprite
        set_reg(CFG_SPRITE_HEIGHT, 24'd0);
        send_item(OP_START, 8'hFF, 16'hFFFF, 8'hFF);
        wait_idle();
        set_reg(CFG_SPRITE_HEIGHT, 24'd1);
        set_reg(CFG_SPRITE_WIDTH, 24'd0);
        send_item(OP_START, 8'h00, 16'h0000, 8'h00);
        wait_idle();
        set_reg(CFG_SPRITE_WIDTH, 24'd3);
        set_reg(CFG_SKIP_MARKER, 24'd0);
        send_item(OP_START, 8'h00, 16'h0000, 8'h00);
        send_code(8'd0);
        send_code(8'd3);
        wait_idle();

        // random phases
        while (items_sent < ITEM_TARGET)
        begin
            pick_config();
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise($urandom_range(1, 12));
                else
                begin
                    send_sprite((cur_h > 6) ? 3 : cur_h);
                    if ($urandom_range(0, 2) == 0)
                        send_noise($urandom_range(1, 4));
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rspb_pkg.sv
rtl/rle_sprite_palette_blitter.sv
test/tb.sv
